@@ hdl/stcc_pkg.sv @@
package stcc_pkg;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_STEPS   = 17;

  typedef logic [1:0] op_t;
  localparam op_t OP_QUERY    = 2'd0;
  localparam op_t OP_STATIC   = 2'd1;
  localparam op_t OP_WAYPOINT = 2'd2;
  localparam op_t OP_PATH_LEN = 2'd3;

  typedef logic [1:0] reason_t;
  localparam reason_t REASON_OK     = 2'd0;
  localparam reason_t REASON_BOUNDS = 2'd1;
  localparam reason_t REASON_STATIC = 2'd2;
  localparam reason_t REASON_MOVING = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_X_LOW        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AGENT_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STATIC_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_COUNT   = 3'd6;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [23:0]        rad;
  } st_ent_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        t;
  } wp_ent_t;

endpackage

@@ hdl/stcc_ram.sv @@
module stcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/spacetime_collision_checker_unit.sv @@
// Space-time collision checker for a circular agent. Beats with tuser 1..3 load static circles,
// path waypoints and path lengths and answer valid. A query (tuser 0) checks the bounds box,
// then walks static slots in order (with an early reject), then paths in order, scanning each
// path's waypoints; for a path whose time falls between waypoints it runs a restoring divide
// and an interpolation, then a circle test (with an early reject). Each table has a single
// read port and one multiplier is shared. Tables have no reset apart from path lengths;
// reading a slot that was never written gives garbage.
module spacetime_collision_checker_unit #(
  parameter int MAX_STATIC    = 16,
  parameter int MAX_PATHS     = 16,
  parameter int MAX_WAYPOINTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // obstacle_index, waypoint_index, pos_x, pos_y, obstacle_radius, time_stamp,
  // waypoint_count, zero fill
  input  logic [stcc_pkg::IN_TDATA_W-1:0] in_tdata,
  // op
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // is_valid, reason, zero fill
  output logic [stcc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [stcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);

  import stcc_pkg::*;

  localparam int SW  = (MAX_STATIC > 1) ? $clog2(MAX_STATIC) : 1;
  localparam int PW  = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int KW  = $clog2(MAX_WAYPOINTS);
  localparam int WD  = MAX_PATHS * MAX_WAYPOINTS;
  localparam int WA  = $clog2(WD);
  localparam int SCW = $clog2(MAX_STATIC + 1);
  localparam int PCW = $clog2(MAX_PATHS + 1);
  localparam int LW  = $clog2(MAX_WAYPOINTS + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BND    = 5'd1;
  localparam logic [4:0] S_ST_RD  = 5'd2;
  localparam logic [4:0] S_ST_EV  = 5'd3;
  localparam logic [4:0] S_PT_CHK = 5'd4;
  localparam logic [4:0] S_WP_RD  = 5'd5;
  localparam logic [4:0] S_WP_EV  = 5'd6;
  localparam logic [4:0] S_DIV    = 5'd7;
  localparam logic [4:0] S_LX_MUL = 5'd8;
  localparam logic [4:0] S_LX_ADD = 5'd9;
  localparam logic [4:0] S_LY_MUL = 5'd10;
  localparam logic [4:0] S_LY_ADD = 5'd11;
  localparam logic [4:0] S_MV_SET = 5'd12;
  localparam logic [4:0] S_HIT0   = 5'd13;
  localparam logic [4:0] S_HIT1   = 5'd14;
  localparam logic [4:0] S_HIT2   = 5'd15;
  localparam logic [4:0] S_HIT3   = 5'd16;
  localparam logic [4:0] S_HIT4   = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;

  // input fields
  logic [3:0]         in_oi;
  logic [3:0]         in_wi;
  logic signed [31:0] in_px;
  logic signed [31:0] in_py;
  logic [23:0]        in_rad;
  logic [31:0]        in_ts;
  logic [4:0]         in_wc;
  op_t                in_op;
  logic               in_acc;

  assign in_oi  = in_tdata[3:0];
  assign in_wi  = in_tdata[7:4];
  assign in_px  = in_tdata[39:8];
  assign in_py  = in_tdata[71:40];
  assign in_rad = in_tdata[95:72];
  assign in_ts  = in_tdata[127:96];
  assign in_wc  = in_tdata[132:128];
  assign in_op  = in_tuser;

  logic [4:0] state_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration
  logic signed [31:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic [23:0]        agent_r;
  logic [4:0]         st_cnt_r, pt_cnt_r;

  // query working registers
  logic signed [31:0] qx_r, qy_r;
  logic [31:0]        qt_r;
  logic [1:0]         bnd_r;
  logic [SCW-1:0]     st_i_r;
  logic [PCW-1:0]     p_r;
  logic [LW-1:0]      k_r;
  wp_ent_t            prv_r, rgt_r;
  logic [32:0]        rem_r;
  logic [31:0]        den_r;
  logic [16:0]        frac_r;
  logic [4:0]         dcnt_r;
  logic signed [31:0] cx_r, cy_r;
  logic signed [32:0] hx_r, hy_r;
  logic [24:0]        hrs_r;
  logic [50:0]        acc_r;
  logic signed [59:0] prod_r;
  reason_t            kind_r, res_r;
  logic               out_valid_r;
  reason_t            out_reason_r;
  logic [LW-1:0]      plen_r [MAX_PATHS];

  // tables
  logic                        st_we;
  logic [SW-1:0]               st_waddr;
  logic [$bits(st_ent_t)-1:0]  st_rdata;
  st_ent_t                     st_wr, st_rd;
  logic                        wp_we;
  logic [WA-1:0]               wp_waddr, wp_raddr;
  logic [$bits(wp_ent_t)-1:0]  wp_rdata;
  wp_ent_t                     wp_wr, wp_rd;

  assign st_wr    = '{x: in_px, y: in_py, rad: in_rad};
  assign wp_wr    = '{x: in_px, y: in_py, t: in_ts};
  assign st_rd    = st_ent_t'(st_rdata);
  assign wp_rd    = wp_ent_t'(wp_rdata);
  assign st_we    = in_acc && (in_op == OP_STATIC) && (9'(in_oi) < 9'(MAX_STATIC));
  assign st_waddr = SW'(in_oi);
  assign wp_we    = in_acc && (in_op == OP_WAYPOINT) && (9'(in_oi) < 9'(MAX_PATHS))
                    && (9'(in_wi) < 9'(MAX_WAYPOINTS));
  assign wp_waddr = WA'(WA'(in_oi) * WA'(MAX_WAYPOINTS) + WA'(in_wi));
  assign wp_raddr = WA'(WA'(p_r[PW-1:0]) * WA'(MAX_WAYPOINTS) + WA'(k_r[KW-1:0]));

  stcc_ram #(.WIDTH($bits(st_ent_t)), .DEPTH(MAX_STATIC)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wr),
    .raddr (st_i_r[SW-1:0]),
    .rdata (st_rdata)
  );

  stcc_ram #(.WIDTH($bits(wp_ent_t)), .DEPTH(WD)) u_wp_ram (
    .clk   (clk),
    .we    (wp_we),
    .waddr (wp_waddr),
    .wdata (wp_wr),
    .raddr (wp_raddr),
    .rdata (wp_rdata)
  );

  // saturated counts and current path length
  logic [SCW-1:0] ns_w;
  logic [PCW-1:0] np_w;
  logic [LW-1:0]  plen_cur;
  assign ns_w = (10'(st_cnt_r) > 10'(MAX_STATIC)) ? SCW'(MAX_STATIC) : SCW'(st_cnt_r);
  assign np_w = (10'(pt_cnt_r) > 10'(MAX_PATHS)) ? PCW'(MAX_PATHS) : PCW'(pt_cnt_r);
  assign plen_cur = plen_r[p_r[PW-1:0]];

  // bounds step: lower side checks c - lim - r, upper side lim - r - c
  logic signed [31:0] bnd_c, bnd_lim;
  logic [34:0]        bnd_d;
  always_comb begin
    unique case (bnd_r)
      2'd0: begin bnd_c = qx_r; bnd_lim = x_low_r;  end
      2'd1: begin bnd_c = qx_r; bnd_lim = x_high_r; end
      2'd2: begin bnd_c = qy_r; bnd_lim = y_low_r;  end
      default: begin bnd_c = qy_r; bnd_lim = y_high_r; end
    endcase
    if (bnd_r[0]) begin
      bnd_d = 35'(bnd_lim) - 35'(bnd_c) - 35'(agent_r);
    end else begin
      bnd_d = 35'(bnd_c) - 35'(bnd_lim) - 35'(agent_r);
    end
  end

  // shared multiplier
  logic signed [25:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [59:0] mul_p;
  always_comb begin
    unique case (state_r)
      S_LX_MUL: begin
        mul_a = signed'({9'd0, frac_r});
        mul_b = 34'(rgt_r.x) - 34'(prv_r.x);
      end
      S_LY_MUL: begin
        mul_a = signed'({9'd0, frac_r});
        mul_b = 34'(rgt_r.y) - 34'(prv_r.y);
      end
      S_HIT1: begin
        mul_a = signed'(hx_r[25:0]);
        mul_b = 34'(hx_r);
      end
      S_HIT2: begin
        mul_a = signed'(hy_r[25:0]);
        mul_b = 34'(hy_r);
      end
      default: begin
        mul_a = signed'({1'b0, hrs_r});
        mul_b = signed'({9'd0, hrs_r});
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // truncate toward zero on the divide by 65536
  logic signed [59:0] lq;
  assign lq = prod_r[59] ? ((prod_r + 60'sd65535) >>> 16) : (prod_r >>> 16);

  logic [32:0] ax_w, ay_w;
  assign ax_w = hx_r[32] ? 33'(-hx_r) : 33'(hx_r);
  assign ay_w = hy_r[32] ? 33'(-hy_r) : 33'(hy_r);

  logic        div_ge;
  logic [32:0] div_r2;
  assign div_ge = (rem_r >= {1'b0, den_r});
  assign div_r2 = div_ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      x_low_r      <= '0;
      x_high_r     <= '0;
      y_low_r      <= '0;
      y_high_r     <= '0;
      agent_r      <= '0;
      st_cnt_r     <= '0;
      pt_cnt_r     <= '0;
      for (int i = 0; i < MAX_PATHS; i++) begin
        plen_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_X_LOW:        x_low_r  <= cfg_data;
          REG_X_HIGH:       x_high_r <= cfg_data;
          REG_Y_LOW:        y_low_r  <= cfg_data;
          REG_Y_HIGH:       y_high_r <= cfg_data;
          REG_AGENT_RADIUS: agent_r  <= cfg_data[23:0];
          REG_STATIC_COUNT: st_cnt_r <= cfg_data[4:0];
          REG_PATH_COUNT:   pt_cnt_r <= cfg_data[4:0];
          default: ;
        endcase
      end

      // the finish step reloads the result beat itself
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            qx_r  <= in_px;
            qy_r  <= in_py;
            qt_r  <= in_ts;
            bnd_r <= 2'd0;
            res_r <= REASON_OK;
            if (in_op == OP_QUERY) begin
              state_r <= S_BND;
            end else begin
              if (in_op == OP_PATH_LEN && 9'(in_oi) < 9'(MAX_PATHS)) begin
                plen_r[PW'(in_oi)] <= (10'(in_wc) > 10'(MAX_WAYPOINTS)) ?
                                      LW'(MAX_WAYPOINTS) : LW'(in_wc);
              end
              state_r <= S_FIN;
            end
          end
        end
        S_BND: begin
          if (bnd_d[34]) begin
            res_r   <= REASON_BOUNDS;
            state_r <= S_FIN;
          end else if (bnd_r == 2'd3) begin
            st_i_r  <= '0;
            state_r <= S_ST_RD;
          end else begin
            bnd_r <= bnd_r + 2'd1;
          end
        end
        S_ST_RD: begin
          if (st_i_r >= ns_w) begin
            p_r     <= '0;
            state_r <= S_PT_CHK;
          end else begin
            state_r <= S_ST_EV;
          end
        end
        S_ST_EV: begin
          hx_r    <= 33'(qx_r) - 33'(st_rd.x);
          hy_r    <= 33'(qy_r) - 33'(st_rd.y);
          hrs_r   <= 25'(agent_r) + 25'(st_rd.rad);
          kind_r  <= REASON_STATIC;
          state_r <= S_HIT0;
        end
        S_PT_CHK: begin
          if (p_r >= np_w) begin
            res_r   <= REASON_OK;
            state_r <= S_FIN;
          end else if (plen_cur == '0) begin
            p_r <= p_r + 1'b1;
          end else begin
            k_r     <= '0;
            state_r <= S_WP_RD;
          end
        end
        S_WP_RD: begin
          state_r <= S_WP_EV;
        end
        S_WP_EV: begin
          if (wp_rd.t >= qt_r) begin
            if (k_r == '0) begin
              cx_r    <= wp_rd.x;
              cy_r    <= wp_rd.y;
              state_r <= S_MV_SET;
            end else begin
              rgt_r   <= wp_rd;
              rem_r   <= {1'b0, qt_r - prv_r.t};
              den_r   <= wp_rd.t - prv_r.t;
              frac_r  <= '0;
              dcnt_r  <= '0;
              state_r <= S_DIV;
            end
          end else begin
            prv_r <= wp_rd;
            if (k_r == LW'(plen_cur - 1'b1)) begin
              // path already ended: park at the last waypoint
              cx_r    <= wp_rd.x;
              cy_r    <= wp_rd.y;
              state_r <= S_MV_SET;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_WP_RD;
            end
          end
        end
        S_DIV: begin
          frac_r <= {frac_r[15:0], div_ge};
          rem_r  <= {div_r2[31:0], 1'b0};
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'(DIV_STEPS - 1)) begin
            state_r <= S_LX_MUL;
          end
        end
        S_LX_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_LX_ADD;
        end
        S_LX_ADD: begin
          cx_r    <= prv_r.x + lq[31:0];
          state_r <= S_LY_MUL;
        end
        S_LY_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_LY_ADD;
        end
        S_LY_ADD: begin
          cy_r    <= prv_r.y + lq[31:0];
          state_r <= S_MV_SET;
        end
        S_MV_SET: begin
          hx_r    <= 33'(qx_r) - 33'(cx_r);
          hy_r    <= 33'(qy_r) - 33'(cy_r);
          hrs_r   <= 25'(agent_r) + 25'(agent_r);
          kind_r  <= REASON_MOVING;
          state_r <= S_HIT0;
        end
        S_HIT0: begin
          // either offset past the radius sum rules out a hit
          if (ax_w >= 33'(hrs_r) || ay_w >= 33'(hrs_r)) begin
            if (kind_r == REASON_STATIC) begin
              st_i_r  <= st_i_r + 1'b1;
              state_r <= S_ST_RD;
            end else begin
              p_r     <= p_r + 1'b1;
              state_r <= S_PT_CHK;
            end
          end else begin
            hx_r    <= signed'(ax_w);
            hy_r    <= signed'(ay_w);
            state_r <= S_HIT1;
          end
        end
        S_HIT1: begin
          prod_r  <= mul_p;
          state_r <= S_HIT2;
        end
        S_HIT2: begin
          acc_r   <= prod_r[50:0];
          prod_r  <= mul_p;
          state_r <= S_HIT3;
        end
        S_HIT3: begin
          acc_r   <= acc_r + prod_r[50:0];
          prod_r  <= mul_p;
          state_r <= S_HIT4;
        end
        S_HIT4: begin
          if (acc_r < prod_r[50:0]) begin
            res_r   <= kind_r;
            state_r <= S_FIN;
          end else if (kind_r == REASON_STATIC) begin
            st_i_r  <= st_i_r + 1'b1;
            state_r <= S_ST_RD;
          end else begin
            p_r     <= p_r + 1'b1;
            state_r <= S_PT_CHK;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_reason_r <= res_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_reason_r, (out_reason_r == REASON_OK)};

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LX_MUL |-> frac_r <= 17'd65536)
    else $error("interpolation fraction above one");

  a_scan_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WP_EV |-> k_r < plen_cur)
    else $error("waypoint scan ran past path length");

  a_hit_operands: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HIT1 |-> (hx_r < 33'(hrs_r)) && (hy_r < 33'(hrs_r)) && !hx_r[32])
    else $error("square operands out of range");

  a_fin_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result beat raised outside finish step");

endmodule

@@ dv/tb_spacetime_collision_checker_unit.sv @@
module tb_spacetime_collision_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import stcc_pkg::*;

  typedef struct {
    op_t          op;
    logic [135:0] data;
  } beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = OP_QUERY;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  spacetime_collision_checker_unit dut (.*);

  // table and register copies for the predictor
  longint          st_x[16], st_y[16], st_r[16];
  bit              st_ok[16];
  longint          wp_x[256], wp_y[256];
  bit [31:0]       wp_t[256];
  bit              wp_ok[256];
  int unsigned     plen[16];
  longint          xl, xh, yl, yh, ar;
  int unsigned     sc, pc;

  beat_t           pending_beats[$];
  reason_t         expected_reasons[$];
  int              errors = 0;
  int              beats_in = 0;
  logic            in_fire = 1'b0;

  initial forever #10 clk = ~clk;

  initial begin
    #500ms;
    $display("FAILURE");
    $finish;
  end

  function automatic bit circle_overlap(longint dx, longint dy, longint rs);
    longint ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= rs || ay >= rs) return 1'b0;
    return (ax * ax + ay * ay) < rs * rs;
  endfunction

  function automatic reason_t query_reason(longint x, longint y, bit [31:0] ts);
    int unsigned ns, np, len, base, k;
    bit          found;
    longint      cx, cy, frac;
    bit [63:0]   num, den;
    ns = sc > 16 ? 16 : sc;
    np = pc > 16 ? 16 : pc;
    if (!(x >= xl + ar && x <= xh - ar && y >= yl + ar && y <= yh - ar)) return REASON_BOUNDS;
    for (int i = 0; i < ns; i++)
      if (circle_overlap(x - st_x[i], y - st_y[i], ar + st_r[i])) return REASON_STATIC;
    for (int p = 0; p < np; p++) begin
      len = plen[p];
      base = p * 16;
      if (len == 0) continue;
      found = 1'b0;
      for (k = 0; k < len; k++)
        if (wp_t[base + k] >= ts) begin
          found = 1'b1;
          break;
        end
      if (!found) begin
        cx = wp_x[base + len - 1];
        cy = wp_y[base + len - 1];
      end else if (k == 0) begin
        cx = wp_x[base];
        cy = wp_y[base];
      end else begin
        num = {32'd0, ts - wp_t[base + k - 1]} << 16;
        den = {32'd0, wp_t[base + k] - wp_t[base + k - 1]};
        frac = longint'(num / den);
        cx = wp_x[base + k - 1] + (frac * (wp_x[base + k] - wp_x[base + k - 1])) / 65536;
        cy = wp_y[base + k - 1] + (frac * (wp_y[base + k] - wp_y[base + k - 1])) / 65536;
      end
      if (circle_overlap(x - cx, y - cy, ar + ar)) return REASON_MOVING;
    end
    return REASON_OK;
  endfunction

  task automatic post_item(op_t op, bit [3:0] oi, bit [3:0] wi, bit [31:0] px, bit [31:0] py,
                           bit [23:0] rad, bit [31:0] ts, bit [4:0] wc);
    beat_t   b;
    reason_t r;
    int      a;
    r = REASON_OK;
    a = oi * 16 + wi;
    case (op)
      OP_QUERY: r = query_reason(longint'($signed(px)), longint'($signed(py)), ts);
      OP_STATIC: begin
        st_x[oi] = longint'($signed(px));
        st_y[oi] = longint'($signed(py));
        st_r[oi] = rad;
        st_ok[oi] = 1'b1;
      end
      OP_WAYPOINT: begin
        wp_x[a] = longint'($signed(px));
        wp_y[a] = longint'($signed(py));
        wp_t[a] = ts;
        wp_ok[a] = 1'b1;
      end
      default: plen[oi] = wc > 16 ? 16 : wc;
    endcase
    b.op = op;
    b.data = {3'd0, wc, ts, rad, py, px, wi, oi};
    pending_beats.push_back(b);
    expected_reasons.push_back(r);
  endtask

  function automatic bit [31:0] near(longint c, int span);
    return 32'(c + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic write_static(bit [3:0] oi);
    post_item(OP_STATIC, oi, $urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22)
              - (1 << 21), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21),
              $urandom, $urandom, $urandom);
  endtask

  // a whole path with non-decreasing times and a walk in space, then its length
  task automatic write_path(bit [3:0] p, int len);
    longint    x, y;
    bit [31:0] t;
    x = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    y = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    t = $urandom_range(0, 1 << 20);
    for (int k = 0; k < len; k++) begin
      post_item(OP_WAYPOINT, p, k, 32'(x), 32'(y), $urandom, t, $urandom);
      x += longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      y += longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      t += $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 1 << 18);
    end
    post_item(OP_PATH_LEN, p, $urandom, $urandom, $urandom, $urandom, $urandom, len);
  endtask

  // never let a query read a table entry that holds nothing yet
  task automatic fill_tables();
    for (int i = 0; i < (sc > 16 ? 16 : sc); i++)
      if (!st_ok[i]) write_static(i);
    for (int p = 0; p < (pc > 16 ? 16 : pc); p++)
      for (int k = 0; k < plen[p]; k++)
        if (!wp_ok[p * 16 + k])
          post_item(OP_WAYPOINT, p, k, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic random_query();
    int          pick, p, k;
    longint      x, y;
    bit [31:0]   ts;
    int unsigned np, ns;
    fill_tables();
    ns = sc > 16 ? 16 : sc;
    np = pc > 16 ? 16 : pc;
    x = 0;
    y = 0;
    ts = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 3 && ns > 0) begin
      k = $urandom_range(0, ns - 1);
      x = st_x[k];
      y = st_y[k];
      post_item(OP_QUERY, $urandom, $urandom, near(x, 1 << 24), near(y, 1 << 24), $urandom, ts,
                $urandom);
    end else if (pick < 7 && np > 0) begin
      p = $urandom_range(0, np - 1);
      if (plen[p] > 0) begin
        k = $urandom_range(0, plen[p] - 1);
        x = wp_x[p * 16 + k];
        y = wp_y[p * 16 + k];
        ts = wp_t[p * 16 + k] + $urandom_range(0, 1 << 19) - (1 << 18);
      end
      post_item(OP_QUERY, $urandom, $urandom, near(x, 1 << 24), near(y, 1 << 24), $urandom, ts,
                $urandom);
    end else if (pick < 9) begin
      post_item(OP_QUERY, $urandom, $urandom, near(0, 1 << 24), near(0, 1 << 24), $urandom, ts,
                $urandom);
    end else begin
      post_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, ts, $urandom);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_LOW:        xl = longint'($signed(val));
      REG_X_HIGH:       xh = longint'($signed(val));
      REG_Y_LOW:        yl = longint'($signed(val));
      REG_Y_HIGH:       yh = longint'($signed(val));
      REG_AGENT_RADIUS: ar = val[23:0];
      REG_STATIC_COUNT: sc = val[4:0];
      REG_PATH_COUNT:   pc = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || expected_reasons.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                          logic [31:0] r, logic [31:0] s, logic [31:0] q);
    write_reg(REG_X_LOW, a);
    write_reg(REG_X_HIGH, b);
    write_reg(REG_Y_LOW, c);
    write_reg(REG_Y_HIGH, d);
    write_reg(REG_AGENT_RADIUS, r);
    write_reg(REG_STATIC_COUNT, s);
    write_reg(REG_PATH_COUNT, q);
  endtask

  initial begin
    int n, sel;
    xl = 0; xh = 0; yl = 0; yh = 0; ar = 0; sc = 0; pc = 0;
    foreach (plen[i]) plen[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset box is the single point at the origin
    post_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
    post_item(OP_QUERY, 15, 15, 32'h0000_0001, 0, 24'hFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    drain();
    write_reg(3'd7, 32'hFFFF_FFFF);
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h00FF_FFFF, 1, 3);
    post_item(OP_QUERY, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
    post_item(OP_STATIC, 0, 0, 32'h0010_0000, 32'h0010_0000, 24'hFF_FFFF, 0, 0);
    post_item(OP_QUERY, 0, 0, 32'h0010_0000, 32'h0011_0000, 0, 0, 0);
    post_item(OP_STATIC, 0, 0, 32'h7000_0000, 32'h7000_0000, 24'd0, 0, 0);
    post_item(OP_WAYPOINT, 0, 0, 32'h0000_0000, 32'h0000_0000, 0, 32'h0001_0000, 0);
    post_item(OP_WAYPOINT, 0, 1, 32'h0400_0000, 32'hFC00_0000, 0, 32'h0003_0000, 0);
    post_item(OP_WAYPOINT, 0, 2, 32'h0400_0000, 32'hFC00_0000, 0, 32'h0003_0000, 0);
    post_item(OP_PATH_LEN, 0, 0, 0, 0, 0, 0, 5'd3);
    post_item(OP_PATH_LEN, 1, 0, 0, 0, 0, 0, 5'd0);
    post_item(OP_PATH_LEN, 2, 0, 0, 0, 0, 0, 5'd31);
    post_item(OP_PATH_LEN, 2, 0, 0, 0, 0, 0, 5'd0);
    post_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
    post_item(OP_QUERY, 0, 0, 32'h0200_0000, 32'hFE00_0000, 0, 32'h0002_0000, 0);
    post_item(OP_QUERY, 0, 0, 32'h0200_0000, 32'hFE00_0000, 0, 32'h0002_8000, 0);
    post_item(OP_QUERY, 0, 0, 32'h0400_0000, 32'hFC00_0000, 0, 32'hFFFF_FFFF, 0);
    post_item(OP_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16, 16);
        1: set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF,
                    31, 31);
        2: set_regs(32'hFE00_0000, 32'h0200_0000, 32'hFE00_0000, 32'h0200_0000, 32'h00FF_FFFF,
                    0, 0);
        default: set_regs(-$urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
                          -$urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
                          $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20),
                          $urandom_range(0, 9) == 0 ? $urandom_range(17, 31) : $urandom_range(0, 6),
                          $urandom_range(0, 9) == 0 ? 16 : $urandom_range(0, 5));
      endcase
      n = 0;
      while (n < 55) begin
        sel = $urandom_range(0, 19);
        if (sel < 11) random_query();
        else if (sel < 14) write_static($urandom);
        else if (sel < 17) write_path($urandom_range(0, 5), $urandom_range(0, 3) == 0 ?
                                      $urandom_range(0, 16) : $urandom_range(1, 4));
        else if (sel < 18) post_item(OP_PATH_LEN, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom);
        else post_item(OP_WAYPOINT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
        n++;
        // throttle the backlog so the drive loop keeps up
        while (pending_beats.size() > 40) @(posedge clk);
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  always @(posedge clk) in_fire <= in_tvalid && in_tready;

  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        void'(pending_beats.pop_front());
        beats_in++;
      end
      if (!in_tvalid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_beats[0].data;
          in_tuser <= pending_beats[0].op;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  int  stall_mode = 0;
  int  mode_left = 100;
  int  hold_left = 0;
  bit  held = 1'b0;

  always @(negedge clk) begin
    if (!held && beats_in >= 300) begin
      held = 1'b1;
      hold_left = 4000;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= $urandom_range(0, 5) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    reason_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reasons.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %h", $realtime, out_tdata);
        errors++;
      end else begin
        want = expected_reasons.pop_front();
        if (out_tdata[0] !== (want == REASON_OK)) begin
          $display("%0t is_valid mismatch: expected %0d, actual %b", $realtime,
                   want == REASON_OK, out_tdata[0]);
          errors++;
        end
        if (out_tdata[2:1] !== want) begin
          $display("%0t reason mismatch: expected %0d, actual %0d", $realtime, want,
                   out_tdata[2:1]);
          errors++;
        end
      end
    end
  end

endmodule
